// ===== hdl/hsfd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the sensor frame decoder.
package hsfd_pkg;

  typedef enum logic [1:0] {
    RC_OK  = 2'd0,
    RC_CRC = 2'd1,
    RC_BUS = 2'd2
  } result_code_t;

  // One finished frame as handed from the front end to the back end
  typedef struct packed {
    result_code_t code;
    logic         kind;
    logic [15:0]  word0;
    logic [15:0]  word1;
  } hsfd_rec_t;

  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Byte positions inside a frame
  localparam logic [2:0] POS_W0_HI = 3'd0;
  localparam logic [2:0] POS_W0_LO = 3'd1;
  localparam logic [2:0] POS_CRC0  = 3'd2;
  localparam logic [2:0] POS_W1_HI = 3'd3;
  localparam logic [2:0] POS_W1_LO = 3'd4;
  localparam logic [2:0] POS_CRC1  = 3'd5;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/hsfd_front.sv =====
// Front end: byte tracking, CRC checking and frame record assembly.
module hsfd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // data_byte
  input  logic [2:0]        in_tuser,   // kind, first, bus_error
  input  logic              q_full,
  output logic              q_push,
  output hsfd_pkg::hsfd_rec_t q_rec
);
  import hsfd_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        kind_r, kind_nxt;
  logic        fail_r, fail_nxt;
  logic [15:0] w0_r, w0_nxt;
  logic [15:0] w1_r, w1_nxt;

  logic       acc, start, kind_e, fail_e, last;
  logic [2:0] pos_e;
  logic [7:0] crc_e, b;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign b         = in_tdata;

  always_comb begin
    // a first flag restarts the count at the high byte of word 0
    pos_e  = (in_tuser[1] || (pos_r > POS_CRC1)) ? POS_W0_HI : pos_r;
    start  = (pos_e == POS_W0_HI);
    kind_e = start ? in_tuser[0] : kind_r;
    crc_e  = start ? CRC_INIT : crc_r;
    fail_e = start ? 1'b0 : fail_r;
    last   = kind_e ? (pos_e == POS_CRC0) : (pos_e == POS_CRC1);

    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    kind_nxt = kind_r;
    fail_nxt = fail_r;
    w0_nxt   = w0_r;
    w1_nxt   = w1_r;
    q_push   = 1'b0;
    q_rec    = '0;

    if (acc) begin
      kind_nxt = kind_e;
      if (in_tuser[2]) begin
        // drop the byte, report the bus error and go idle
        pos_nxt     = POS_W0_HI;
        crc_nxt     = CRC_INIT;
        fail_nxt    = 1'b0;
        q_push      = 1'b1;
        q_rec.code  = RC_BUS;
        q_rec.kind  = kind_e;
      end else begin
        crc_nxt  = crc8_byte(crc_e, b);
        fail_nxt = fail_e;
        unique case (pos_e)
          POS_W0_HI: w0_nxt = {b, w0_r[7:0]};
          POS_W0_LO: w0_nxt = {w0_r[15:8], b};
          POS_W1_HI: w1_nxt = {b, w1_r[7:0]};
          POS_W1_LO: w1_nxt = {w1_r[15:8], b};
          default: begin
            if (b != crc_e) fail_nxt = 1'b1;
            crc_nxt = CRC_INIT;
          end
        endcase
        if (last) begin
          pos_nxt     = POS_W0_HI;
          crc_nxt     = CRC_INIT;
          fail_nxt    = 1'b0;
          q_push      = 1'b1;
          q_rec.code  = ((b != crc_e) || fail_e) ? RC_CRC : RC_OK;
          q_rec.kind  = kind_e;
          q_rec.word0 = w0_nxt;
          q_rec.word1 = w1_nxt;
        end else begin
          pos_nxt = pos_e + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_W0_HI;
      crc_r  <= CRC_INIT;
      kind_r <= 1'b0;
      fail_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      kind_r <= kind_nxt;
      fail_r <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w0_r <= w0_nxt;
    w1_r <= w1_nxt;
  end

endmodule

// ===== hdl/hsfd_fifo.sv =====
// Short queue of frame records between the front and back ends.
module hsfd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  hsfd_pkg::hsfd_rec_t wr_rec,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output hsfd_pkg::hsfd_rec_t rd_rec
);
  import hsfd_pkg::*;

  hsfd_rec_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_rec    = mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_rec;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

// ===== hdl/hsfd_back.sv =====
// Back end: scales measurement words and drives the result register.
module hsfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  hsfd_pkg::hsfd_rec_t q_rec,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [47:0]         out_tdata,  // temperature_centi, humidity_centi, status_word
  output logic [2:0]          out_tuser   // result_code, frame_kind
);
  import hsfd_pkg::*;

  // stage 1: products
  logic         v1_r, v1_nxt;
  result_code_t code1_r;
  logic         kind1_r;
  logic [30:0]  tprod_r;
  logic [29:0]  hprod_r;
  logic [15:0]  stat1_r;

  // stage 2: result register
  logic         v2_r, v2_nxt;
  result_code_t code2_r;
  logic         kind2_r;
  logic [14:0]  temp2_r, temp2_nxt;
  logic [13:0]  hum2_r, hum2_nxt;
  logic [15:0]  stat2_r, stat2_nxt;

  logic en1, en2;
  logic [16:0] tsum, hsum;
  logic [14:0] tq;
  logic [13:0] hq;
  logic ok_meas, ok_stat;

  assign en2   = !v2_r || out_tready;
  assign en1   = !v1_r || en2;
  assign q_pop = en1 && q_not_empty;

  always_comb begin
    v1_nxt = en1 ? q_not_empty : v1_r;
    v2_nxt = en2 ? v1_r : v2_r;
  end

  // floor(x / 65535) with x = a*2^16 + b: a plus one when a + b reaches 65535
  always_comb begin
    tsum = {2'b0, tprod_r[30:16]} + {1'b0, tprod_r[15:0]};
    hsum = {3'b0, hprod_r[29:16]} + {1'b0, hprod_r[15:0]};
    tq   = tprod_r[30:16] + {14'b0, (tsum >= FULL_SCALE)};
    hq   = hprod_r[29:16] + {13'b0, (hsum >= FULL_SCALE)};
    ok_meas = (code1_r == RC_OK) && !kind1_r;
    ok_stat = (code1_r == RC_OK) && kind1_r;
    temp2_nxt = ok_meas ? (tq - TEMP_OFFSET) : '0;
    hum2_nxt  = ok_meas ? hq : '0;
    stat2_nxt = ok_stat ? stat1_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      code1_r <= q_rec.code;
      kind1_r <= q_rec.kind;
      tprod_r <= 31'(q_rec.word0 * TEMP_SCALE);
      hprod_r <= 30'(q_rec.word1 * HUM_SCALE);
      stat1_r <= q_rec.word0;
    end
    if (en2) begin
      code2_r <= code1_r;
      kind2_r <= kind1_r;
      temp2_r <= temp2_nxt;
      hum2_r  <= hum2_nxt;
      stat2_r <= stat2_nxt;
    end
  end

  assign out_tvalid = v2_r;
  assign out_tdata  = {3'b000, stat2_r, hum2_r, temp2_r};
  assign out_tuser  = {kind2_r, code2_r};

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !out_tready) |=> (v2_r && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");
  a_pop_advances: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> v1_r) else $error("popped record lost");
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> v1_r) else $error("stage 1 dropped while stalled");

endmodule

// ===== hdl/humidity_sensor_frame_decoder.sv =====
// Top level of the humidity/temperature sensor frame decoder.
//
//  channel | direction | tdata                               | tuser
//  --------+-----------+-------------------------------------+-------------------------------
//  in_     | slave     | data_byte                           | kind, first, bus_error
//  out_    | master    | temperature_centi, humidity_centi,  | result_code, frame_kind
//          |           | status_word                         |
//
// One byte per cycle is accepted unless the queue is full; the front end updates the CRC
// in the accept cycle. The queue is written at the edge that accepts a frame's last byte;
// the record then passes the multiply stage and the result register, which drives out_tvalid.
// Up to four finished frames sit in the queue while out_tready is low;
// in_tready drops only when the queue is full. Reset is synchronous and empties all stages.
module humidity_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [2:0]  in_tuser,   // [0] kind, [1] first, [2] bus_error
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi,
                                  // [44:29] status_word, [47:45] zero
  output logic [2:0]  out_tuser   // [1:0] result_code, [2] frame_kind
);
  import hsfd_pkg::*;

  hsfd_rec_t push_rec, pop_rec;
  logic      push, pop, full, not_empty;

  hsfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_rec     (push_rec)
  );

  hsfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (push_rec),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_rec    (pop_rec)
  );

  hsfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (not_empty),
    .q_rec       (pop_rec),
    .q_pop       (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== sim/tb_humidity_sensor_frame_decoder.sv =====
// Self-checking testbench for the sensor frame decoder: directed frames, then random bytes.
`timescale 1ns / 100ps

module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_BYTES = 1450;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 600;
  localparam int WATCHDOG_NS  = 2_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic K_MEAS   = 1'b0;
  localparam logic K_STATUS = 1'b1;

  localparam logic signed [14:0] TEMP_AT_ZERO = -15'sd4500;
  localparam logic [14:0]        TEMP_AT_FULL = 15'd13000;
  localparam logic [13:0]        HUM_AT_FULL  = 14'd10000;

  typedef struct packed {
    result_code_t code;
    logic         kind;
    logic [14:0]  temp;
    logic [13:0]  hum;
    logic [15:0]  status;
  } frame_result_t;

  typedef struct {
    logic          kind;
    logic          first;
    logic [7:0]    data_byte;
    logic          bus_error;
    bit            pinned;
    frame_result_t pinned_res;
  } byte_item_t;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_RANDOM,
    DRAIN_SPARSE
  } drain_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic [2:0]  in_tuser;   // [0] kind, [1] first, [2] bus_error
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [14:0] temperature_centi, [28:15] humidity_centi,
                           // [44:29] status_word
  logic [2:0]  out_tuser;  // [1:0] result_code, [2] frame_kind

  humidity_sensor_frame_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Decoder state mirrored by the predictor
  logic [2:0]  dec_pos  = POS_W0_HI;
  logic [7:0]  dec_crc  = CRC_INIT;
  logic        dec_kind = K_MEAS;
  logic [15:0] dec_w0   = '0;
  logic [15:0] dec_w1   = '0;
  logic        dec_bad  = 1'b0;

  byte_item_t    byte_stream[$];
  frame_result_t frames_due[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  results_checked = 0;
  int  input_stalls = 0;
  int  n_ok_meas = 0;
  int  n_ok_status = 0;
  int  n_crc = 0;
  int  n_bus = 0;
  bit  stim_done = 1'b0;
  bit  long_hold_done = 1'b0;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  function automatic frame_result_t frame_exp(input result_code_t code, input logic kind,
                                              input logic [14:0] temp, input logic [13:0] hum,
                                              input logic [15:0] status);
    frame_result_t r;
    r.code   = code;
    r.kind   = kind;
    r.temp   = temp;
    r.hum    = hum;
    r.status = status;
    return r;
  endfunction

  task automatic add_row(input logic k, input logic f, input logic [7:0] b, input logic e,
                         input bit pin, input frame_result_t res);
    byte_item_t it;
    it.kind       = k;
    it.first      = f;
    it.data_byte  = b;
    it.bus_error  = e;
    it.pinned     = pin;
    it.pinned_res = res;
    byte_stream.push_back(it);
  endtask

  // Advance the mirrored decoder by one accepted byte; queue the frame result it ends with.
  task automatic predict_frame_byte(input byte_item_t it);
    frame_result_t r;
    logic [2:0]    last_pos;
    int unsigned   t_raw;
    int unsigned   h_raw;
    int            t_centi;
    bit            emit;
    r = '0;
    emit = 1'b0;
    if (dec_pos > POS_CRC1) dec_pos = POS_W0_HI;
    if (it.first || dec_pos == POS_W0_HI) begin
      dec_pos  = POS_W0_HI;
      dec_crc  = CRC_INIT;
      dec_bad  = 1'b0;
      dec_kind = it.kind;
    end
    if (it.bus_error) begin
      r.code = RC_BUS;
      r.kind = dec_kind;
      emit = 1'b1;
    end else begin
      case (dec_pos)
        POS_W0_HI: begin
          dec_w0[15:8] = it.data_byte;
          dec_crc = crc8_step(dec_crc, it.data_byte);
        end
        POS_W0_LO: begin
          dec_w0[7:0] = it.data_byte;
          dec_crc = crc8_step(dec_crc, it.data_byte);
        end
        POS_W1_HI: begin
          dec_w1[15:8] = it.data_byte;
          dec_crc = crc8_step(dec_crc, it.data_byte);
        end
        POS_W1_LO: begin
          dec_w1[7:0] = it.data_byte;
          dec_crc = crc8_step(dec_crc, it.data_byte);
        end
        default: begin
          if (it.data_byte != dec_crc) dec_bad = 1'b1;
          dec_crc = CRC_INIT;
        end
      endcase
      last_pos = (dec_kind == K_STATUS) ? POS_CRC0 : POS_CRC1;
      if (dec_pos < last_pos) begin
        dec_pos = dec_pos + 3'd1;
      end else begin
        emit = 1'b1;
        r.code = dec_bad ? RC_CRC : RC_OK;
        r.kind = dec_kind;
        if (!dec_bad) begin
          if (dec_kind == K_STATUS) begin
            r.status = dec_w0;
          end else begin
            t_raw   = (32'd17500 * {16'd0, dec_w0}) / 32'd65535;
            h_raw   = (32'd10000 * {16'd0, dec_w1}) / 32'd65535;
            t_centi = int'(t_raw) - 4500;
            r.temp  = t_centi[14:0];
            r.hum   = h_raw[13:0];
          end
        end
      end
    end
    if (emit) begin
      dec_pos = POS_W0_HI;
      dec_crc = CRC_INIT;
      dec_bad = 1'b0;
      case (r.code)
        RC_OK:   if (r.kind == K_STATUS) n_ok_status++; else n_ok_meas++;
        RC_CRC:  n_crc++;
        default: n_bus++;
      endcase
      frames_due.push_back(it.pinned ? it.pinned_res : r);
    end
  endtask

  // Sender: bursts of random length separated by random gaps
  initial begin : feed
    byte_item_t it;
    int burst;
    int gap;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    do @(posedge clk); while (!rst_n);
    while (byte_stream.size() != 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
      while (burst > 0 && byte_stream.size() != 0) begin
        it = byte_stream.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.data_byte;
        in_tuser  <= {it.bus_error, it.first, it.kind};
        do @(posedge clk); while (!in_tready);
        predict_frame_byte(it);
        bytes_sent++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: changing stall patterns plus one long hold-off while input keeps coming
  initial begin : drain
    drain_mode_t mode;
    int hold;
    int phase_left;
    int tick;
    out_tready <= 1'b0;
    mode = DRAIN_FREE;
    hold = 0;
    phase_left = 0;
    tick = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold == 0 && !long_hold_done && bytes_sent >= HOLD_AFTER) begin
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (phase_left == 0) begin
        mode = drain_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      tick++;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          DRAIN_FREE:   out_tready <= 1'b1;
          DRAIN_RANDOM: out_tready <= ($urandom_range(0, 1) != 0);
          default:      out_tready <= (tick % 4 == 0);
        endcase
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t got;
    frame_result_t want;
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
    if (rst_n && out_tvalid && out_tready) begin
      got.code   = result_code_t'(out_tuser[1:0]);
      got.kind   = out_tuser[2];
      got.temp   = out_tdata[14:0];
      got.hum    = out_tdata[28:15];
      got.status = out_tdata[44:29];
      if (frames_due.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t unexpected result: code=%0d kind=%0d temp=%0d hum=%0d status=%h",
                   $time, got.code, got.kind, $signed(got.temp), got.hum, got.status);
        errors++;
      end else begin
        want = frames_due.pop_front();
        results_checked++;
        if (got !== want) begin
          if (errors < MAX_REPORTS)
            $display({"%0t result mismatch: want code=%0d kind=%0d temp=%0d hum=%0d ",
                      "status=%h, got code=%0d kind=%0d temp=%0d hum=%0d status=%h"},
                     $time, want.code, want.kind, $signed(want.temp), want.hum, want.status,
                     got.code, got.kind, $signed(got.temp), got.hum, got.status);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : main
    logic [7:0]  fb [0:5];
    logic [15:0] w0;
    logic [15:0] w1;
    logic        fk;
    int          n;
    int          i;
    int          err_at;
    int          roll;
    int          directed_rows;
    bit          force_first;

    rst_n <= 1'b0;

    // Directed table: extremes, both frame kinds, idle start, restart, checksum and bus errors
    add_row(K_MEAS,   1'b1, 8'h00, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, 8'h00, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, word_crc(16'h0000), 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, 8'h00, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, 8'h00, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, word_crc(16'h0000), 1'b0, 1'b1,
            frame_exp(RC_OK, K_MEAS, TEMP_AT_ZERO, '0, '0));
    add_row(K_MEAS,   1'b1, 8'hFF, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, 8'hFF, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, word_crc(16'hFFFF), 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, 8'hFF, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, 8'hFF, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, word_crc(16'hFFFF), 1'b0, 1'b1,
            frame_exp(RC_OK, K_MEAS, TEMP_AT_FULL, HUM_AT_FULL, '0));
    // start a status frame from idle without the first flag
    add_row(K_STATUS, 1'b0, 8'h80, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, 8'h10, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, word_crc(16'h8010), 1'b0, 1'b1,
            frame_exp(RC_OK, K_STATUS, '0, '0, 16'h8010));
    add_row(K_STATUS, 1'b1, 8'hBE, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, 8'hEF, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b0, word_crc(16'hBEEF) ^ 8'h01, 1'b0, 1'b1,
            frame_exp(RC_CRC, K_STATUS, '0, '0, '0));
    // abandon a measurement after one byte and restart as a status frame
    add_row(K_MEAS,   1'b1, 8'h12, 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b1, 8'h04, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, 8'h51, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, word_crc(16'h0451), 1'b0, 1'b0, '0);
    add_row(K_STATUS, 1'b1, 8'h55, 1'b0, 1'b0, '0);
    add_row(K_MEAS,   1'b0, 8'hAA, 1'b1, 1'b1, frame_exp(RC_BUS, K_STATUS, '0, '0, '0));
    add_row(K_MEAS,   1'b0, 8'hFF, 1'b1, 1'b1, frame_exp(RC_BUS, K_MEAS, '0, '0, '0));
    directed_rows = byte_stream.size();

    // Random part: mostly well-formed frames, some truncated, bus-errored or pure noise
    force_first = 1'b1;
    while (byte_stream.size() < directed_rows + RANDOM_BYTES) begin
      roll = $urandom_range(0, 19);
      if (roll == 2) begin
        add_row(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);
        force_first = 1'b1;
        continue;
      end
      fk = 1'($urandom_range(0, 1));
      w0 = 16'($urandom);
      w1 = 16'($urandom);
      if ($urandom_range(0, 15) == 0) w0 = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(0, 15) == 0) w1 = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      fb = '{w0[15:8], w0[7:0], word_crc(w0), w1[15:8], w1[7:0], word_crc(w1)};
      if ($urandom_range(0, 7) == 0) fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 7) == 0) fb[5] = fb[5] ^ 8'($urandom_range(1, 255));
      n = (fk == K_STATUS) ? 3 : 6;
      err_at = -1;
      if (roll == 0) err_at = $urandom_range(0, n - 1);
      else if (roll == 1) n = $urandom_range(1, n - 1);
      for (i = 0; i < n; i++) begin
        if (err_at >= 0 && i > err_at) break;
        if (i == 0)
          add_row(fk, force_first || ($urandom_range(0, 3) != 0), fb[i], (i == err_at),
                  1'b0, '0);
        else
          add_row(1'($urandom_range(0, 1)), 1'b0, fb[i], (i == err_at), 1'b0, '0);
      end
      // a cut-off frame must be followed by an explicit restart
      force_first = (roll == 1);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (!stim_done) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes and %0d results: %0d good measurements, %0d good status,",
             bytes_sent, results_checked, n_ok_meas, n_ok_status);
    $display("%0d checksum failures, %0d bus errors, %0d input stall cycles under output hold.",
             n_crc, n_bus, input_stalls);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
